@@ rtl/smc_pkg.sv @@
// Shared constants and types for the stepper motion controller.
package smc_pkg;

   localparam int POSITION_BITS = 32;
   localparam int DELAY_BITS    = 16;
   localparam int STEPS_BITS    = 32;
   localparam int SDIST_BITS    = 24;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam int DIV_STEPS     = STEPS_BITS;
   localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

   localparam logic [STEPS_BITS-1:0] HOME_BURST = STEPS_BITS'(10);

   // Configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_PULSE_DELAY   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRAVEL_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_DISTANCE = 2'd2;

   // Command codes
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_MOVE_BY  = 2'd1;
   localparam logic [1:0] OP_MOVE_TO  = 2'd2;
   localparam logic [1:0] OP_HOME     = 2'd3;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_HIGH = 4'b0010,
      PH_LOW  = 4'b0100,
      PH_GAP  = 4'b1000
   } pulse_phase_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_FIN  = 3'b100
   } ctrl_state_type;

endpackage

@@ rtl/stepper_motion_controller.sv @@
// Stepper step/direction controller with position tracking: each input word is one
// tick and returns one result word. A tick without a new move is committed in the cycle it is accepted.
// A move command (op 1 or 2) accepted while idle returns its result word only after a
// divide: the step count comes from a shift-subtract divider that resolves one
// quotient bit per cycle. The controller starts it, waits in S_DIV for done, and
// finishes the tick in S_FIN once the output is free. The block holds req_tready low
// while the move is in S_DIV or S_FIN. Homing and step timing need no divide.
module stepper_motion_controller
   import smc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // tdata: distance[31:0], limit_switch[32], zero pad [39:33]
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [39:0]              req_tdata,
   // tuser: op[1:0]
   input  logic [1:0]               req_tuser,
   // tdata: step_out[0], dir_out[1], busy_res[2], position[34:3], rejected[35],
   //        step_blocked[36], zero pad [39:37]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [39:0]              rsp_tdata,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam logic signed [POSITION_BITS+1:0] POS_MAX =
      (POSITION_BITS+2)'((64'd1 << (POSITION_BITS - 1)) - 64'd1);
   localparam logic signed [POSITION_BITS+1:0] POS_MIN = -POS_MAX - 1;

   // configuration
   logic [DELAY_BITS-1:0]           pulse_delay_ff;
   logic signed [POSITION_BITS-1:0] travel_limit_ff;
   logic [SDIST_BITS-1:0]           step_distance_ff;

   // motion state
   logic signed [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [STEPS_BITS-1:0]           steps_ff, steps_in;
   logic                            fwd_ff, fwd_in;
   pulse_phase_type                 phase_ff, phase_in;
   logic [DELAY_BITS-1:0]           cd_ff, cd_in;
   logic                            home_ff, home_in;

   ctrl_state_type                  st_ff, st_in;
   logic                            sw_ff;
   logic                            neg_ff;

   logic                            rsp_valid_ff;
   logic [39:0]                     rsp_data_ff;

   logic [1:0]                      op;
   logic signed [POSITION_BITS-1:0] req_dist;
   logic                            sw;
   logic                            accept;
   logic                            out_free;
   logic                            busy;
   logic                            start_div;
   logic                            commit;
   logic                            cur_sw;
   logic signed [POSITION_BITS:0]   diff;
   logic [STEPS_BITS-1:0]           diff_mag;
   logic [SDIST_BITS-1:0]           div_den;
   logic                            div_done;
   logic [STEPS_BITS-1:0]           div_quo;
   logic [DELAY_BITS-1:0]           delay_load;

   logic                            so_c, blk_c, rej_c, busy_c;

   assign op       = req_tuser;
   assign req_dist = req_tdata[POSITION_BITS-1:0];
   assign sw       = req_tdata[POSITION_BITS];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (st_ff == S_IDLE) && out_free;
   assign accept   = req_tvalid && req_tready;
   assign busy     = home_ff || (steps_ff != '0) || (phase_ff != PH_IDLE);
   assign start_div = accept && !busy && (op == OP_MOVE_BY || op == OP_MOVE_TO);
   assign commit   = (accept && !start_div) || (st_ff == S_FIN && out_free);
   assign cur_sw   = (st_ff == S_FIN) ? sw_ff : sw;

   assign delay_load = (pulse_delay_ff == '0) ? '0 : pulse_delay_ff - 1'b1;

   always_comb begin
      if (op == OP_MOVE_TO)
         diff = {req_dist[POSITION_BITS-1], req_dist} - {pos_ff[POSITION_BITS-1], pos_ff};
      else
         diff = {req_dist[POSITION_BITS-1], req_dist};
      diff_mag = diff[POSITION_BITS] ? STEPS_BITS'(-diff) : STEPS_BITS'(diff);
      div_den  = (step_distance_ff == '0) ? SDIST_BITS'(1) : step_distance_ff;
   end

   smc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_div),
      .dividend (diff_mag),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // one tick of motion: a divide finish or optional command start, phase timing, then the step decision
   always_comb begin
      logic                          do_decide;
      logic signed [POSITION_BITS+1:0] p_ext;
      logic signed [POSITION_BITS+1:0] sd_ext;
      logic signed [POSITION_BITS+1:0] p_new;
      logic                          skip;

      do_decide = 1'b0;
      skip      = 1'b0;
      so_c      = 1'b0;
      blk_c     = 1'b0;
      rej_c     = 1'b0;
      pos_in    = pos_ff;
      steps_in  = steps_ff;
      fwd_in    = fwd_ff;
      phase_in  = phase_ff;
      cd_in     = cd_ff;
      home_in   = home_ff;
      p_ext     = (POSITION_BITS+2)'(pos_ff);
      sd_ext    = (POSITION_BITS+2)'({1'b0, step_distance_ff});
      p_new     = p_ext;

      if (st_ff == S_FIN) begin
         fwd_in    = (div_quo != '0) && !neg_ff;
         steps_in  = div_quo;
         phase_in  = PH_IDLE;
         do_decide = 1'b1;
      end else begin
         rej_c = (op != OP_TICK) && busy;
         if (op == OP_HOME && !busy) begin
            fwd_in    = 1'b0;
            home_in   = 1'b1;
            steps_in  = '0;
            phase_in  = PH_IDLE;
            do_decide = 1'b1;
         end else if (busy) begin
            unique case (phase_ff)
               PH_HIGH: begin
                  if (cd_ff != '0) begin
                     cd_in = cd_ff - 1'b1;
                     so_c  = 1'b1;
                  end else begin
                     phase_in = PH_LOW;
                     cd_in    = delay_load;
                  end
               end
               PH_LOW: begin
                  if (cd_ff != '0) begin
                     cd_in = cd_ff - 1'b1;
                  end else begin
                     // advance the position, clamped to the signed range
                     if (fwd_ff) begin
                        p_new = p_ext + sd_ext;
                        if (p_new > POS_MAX) p_new = POS_MAX;
                     end else begin
                        p_new = p_ext - sd_ext;
                        if (p_new < POS_MIN) p_new = POS_MIN;
                     end
                     pos_in   = POSITION_BITS'(p_new);
                     phase_in = PH_GAP;
                     cd_in    = delay_load;
                  end
               end
               PH_GAP: begin
                  if (cd_ff != '0) begin
                     cd_in = cd_ff - 1'b1;
                  end else begin
                     phase_in  = PH_IDLE;
                     do_decide = 1'b1;
                  end
               end
               default: begin
                  do_decide = 1'b1;
               end
            endcase
         end
      end

      if (do_decide) begin
         if (steps_in == '0) begin
            if (!home_in) begin
               skip = 1'b1;
            end else if (cur_sw) begin
               pos_in  = '0;
               home_in = 1'b0;
               skip    = 1'b1;
            end else begin
               steps_in = HOME_BURST;
            end
         end
         if (!skip) begin
            steps_in = steps_in - 1'b1;
            if ((cur_sw && !fwd_in) || (fwd_in && (pos_in >= travel_limit_ff))) begin
               blk_c    = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_HIGH;
               cd_in    = delay_load;
               so_c     = 1'b1;
            end
         end
      end

      busy_c = home_in || (steps_in != '0) || (phase_in != PH_IDLE);
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (start_div) st_in = S_DIV;
         S_DIV:  if (div_done) st_in = S_FIN;
         S_FIN:  if (out_free) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff            <= S_IDLE;
         pulse_delay_ff   <= DELAY_BITS'(1000);
         travel_limit_ff  <= POSITION_BITS'(32'sh7FFFFFFF);
         step_distance_ff <= SDIST_BITS'(65536);
         pos_ff           <= '0;
         steps_ff         <= '0;
         fwd_ff           <= 1'b0;
         phase_ff         <= PH_IDLE;
         cd_ff            <= '0;
         home_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PULSE_DELAY:   pulse_delay_ff   <= csr_wdata[DELAY_BITS-1:0];
               CSR_TRAVEL_LIMIT:  travel_limit_ff  <= csr_wdata[POSITION_BITS-1:0];
               CSR_STEP_DISTANCE: step_distance_ff <= csr_wdata[SDIST_BITS-1:0];
               default: ;
            endcase
         end
         if (commit) begin
            pos_ff       <= pos_in;
            steps_ff     <= steps_in;
            fwd_ff       <= fwd_in;
            phase_ff     <= phase_in;
            cd_ff        <= cd_in;
            home_ff      <= home_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // hold the switch and sign of the move while the divide runs
      if (start_div) begin
         sw_ff  <= sw;
         neg_ff <= diff[POSITION_BITS];
      end
      if (commit)
         rsp_data_ff <= {3'b000, blk_c, rej_c, pos_in, busy_c, fwd_in, so_c};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_div_to_fin : assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_DIV && div_done) |=> st_ff == S_FIN)
      else $error("divide result not taken");
   a_step_enters_high : assert property (@(posedge clock) disable iff (reset)
      (commit && so_c) |=> phase_ff == PH_HIGH)
      else $error("step line high outside high phase");
   a_step_xor_block : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[0] && rsp_data_ff[POSITION_BITS+4]))
      else $error("step and skip in one word");
   a_start_only_idle : assert property (@(posedge clock) disable iff (reset)
      start_div |-> !busy && st_ff == S_IDLE)
      else $error("move started while busy");

endmodule

@@ rtl/smc_div.sv @@
// Shift-subtract unsigned divider, one quotient bit per cycle.
module smc_div
   import smc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [STEPS_BITS-1:0] dividend,
   input  logic [SDIST_BITS-1:0] divisor,
   output logic                  done,
   output logic [STEPS_BITS-1:0] quotient
);

   logic                    run_ff, run_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SDIST_BITS-1:0]   rem_ff, rem_in;
   logic [SDIST_BITS-1:0]   den_ff, den_in;
   logic [STEPS_BITS-1:0]   quo_ff, quo_in;
   logic [SDIST_BITS:0]     trial;
   logic                    last;

   assign last  = (cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1));
   assign trial = {rem_ff, quo_ff[STEPS_BITS-1]};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         den_in = divisor;
         quo_in = dividend;
      end else if (run_ff) begin
         // shift one dividend bit in, subtract when it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = SDIST_BITS'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[STEPS_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[SDIST_BITS-1:0];
            quo_in = {quo_ff[STEPS_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_after_run : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff) && !run_ff)
      else $error("divider done without a finished run");
   a_count_zero_on_start : assert property (@(posedge clock) disable iff (reset)
      start |=> cnt_ff == '0 && run_ff)
      else $error("divider did not restart");
   a_no_start_while_run : assert property (@(posedge clock) disable iff (reset)
      run_ff |-> !start)
      else $error("divider restarted mid-run");

endmodule
